[sv/vmmio_pkg.sv]
package vmmio_pkg;

    // Default sizing of the queue set
    localparam int QUEUE_COUNT_DEF    = 2;
    localparam int QUEUE_SIZE_MAX_DEF = 256;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 64;
    localparam int MAC_W      = 48;
    localparam logic [MAC_W-1:0] MAC_RESET = 48'h5634_1200_5452;

    // Access commands
    localparam logic [1:0] CMD_READ     = 2'd0;
    localparam logic [1:0] CMD_WRITE    = 2'd1;
    localparam logic [1:0] CMD_COMPLETE = 2'd2;

    // Register window offsets (word aligned)
    localparam logic [11:0] OFF_MAGIC        = 12'h000;
    localparam logic [11:0] OFF_VERSION      = 12'h004;
    localparam logic [11:0] OFF_DEVICE_ID    = 12'h008;
    localparam logic [11:0] OFF_VENDOR_ID    = 12'h00c;
    localparam logic [11:0] OFF_DEV_FEAT     = 12'h010;
    localparam logic [11:0] OFF_DEV_FEAT_SEL = 12'h014;
    localparam logic [11:0] OFF_DRV_FEAT     = 12'h020;
    localparam logic [11:0] OFF_DRV_FEAT_SEL = 12'h024;
    localparam logic [11:0] OFF_QUEUE_SEL    = 12'h030;
    localparam logic [11:0] OFF_QUEUE_MAX    = 12'h034;
    localparam logic [11:0] OFF_QUEUE_SIZE   = 12'h038;
    localparam logic [11:0] OFF_QUEUE_READY  = 12'h044;
    localparam logic [11:0] OFF_NOTIFY       = 12'h050;
    localparam logic [11:0] OFF_IRQ_STATUS   = 12'h060;
    localparam logic [11:0] OFF_IRQ_ACK      = 12'h064;
    localparam logic [11:0] OFF_STATUS       = 12'h070;
    localparam logic [11:0] OFF_DESC_LO      = 12'h080;
    localparam logic [11:0] OFF_DESC_HI      = 12'h084;
    localparam logic [11:0] OFF_AVAIL_LO     = 12'h090;
    localparam logic [11:0] OFF_AVAIL_HI     = 12'h094;
    localparam logic [11:0] OFF_USED_LO      = 12'h0a0;
    localparam logic [11:0] OFF_USED_HI      = 12'h0a4;
    localparam logic [11:0] OFF_MAC_LO       = 12'h100;
    localparam logic [11:0] OFF_MAC_HI       = 12'h104;

    // Identity words
    localparam logic [31:0] MAGIC_VALUE   = 32'h7472_6976;
    localparam logic [31:0] VERSION_VALUE = 32'd2;
    localparam logic [31:0] DEVICE_ID_NET = 32'd1;
    localparam logic [31:0] VENDOR_VALUE  = 32'h554d_4551;
    localparam logic [31:0] DEV_FEAT_W0   = 32'h0000_0020;
    localparam logic [31:0] DEV_FEAT_W1   = 32'h0000_0001;

    localparam int STATUS_DRIVER_OK_BIT = 2;

    // Bus access item
    typedef struct packed {
        logic [1:0]  cmd;
        logic [11:0] offset;
        logic [2:0]  byte_count;
        logic [31:0] write_data;
    } access_t;

    // Result item
    typedef struct packed {
        logic [31:0] read_data;
        logic        tx_notify;
        logic        irq_pending;
        logic        rx_queue_live;
        logic        tx_queue_live;
    } result_t;

    // Byte-lane merge of written data into a 32-bit word
    function automatic logic [31:0] merge_lanes(
        input logic [31:0] old_word,
        input logic [31:0] mask,
        input logic [31:0] data
    );
        return (old_word & ~mask) | (data & mask);
    endfunction

endpackage

[sv/vmmio_regs.sv]
module vmmio_regs #(
    parameter int QUEUE_COUNT    = vmmio_pkg::QUEUE_COUNT_DEF,
    parameter int QUEUE_SIZE_MAX = vmmio_pkg::QUEUE_SIZE_MAX_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          update,
    input  vmmio_pkg::access_t            access,
    input  logic [vmmio_pkg::MAC_W-1:0]   mac,
    output vmmio_pkg::result_t            result
);

    localparam int QSIZE_W = $clog2(QUEUE_SIZE_MAX + 1);

    // Register state
    logic [31:0]        dev_feat_sel_reg, dev_feat_sel_next;
    logic               drv_feat_sel_reg, drv_feat_sel_next;
    logic [31:0]        drv_feat_reg [2];
    logic [31:0]        drv_feat_next [2];
    logic [31:0]        queue_sel_reg, queue_sel_next;
    logic [31:0]        status_reg, status_next;
    logic               irq_reg, irq_next;
    logic [QSIZE_W-1:0] qsize_reg [QUEUE_COUNT];
    logic [QSIZE_W-1:0] qsize_next [QUEUE_COUNT];
    logic               qen_reg [QUEUE_COUNT];
    logic               qen_next [QUEUE_COUNT];
    logic [63:0]        desc_reg [QUEUE_COUNT];
    logic [63:0]        desc_next [QUEUE_COUNT];
    logic [63:0]        avail_reg [QUEUE_COUNT];
    logic [63:0]        avail_next [QUEUE_COUNT];
    logic [63:0]        used_reg [QUEUE_COUNT];
    logic [63:0]        used_next [QUEUE_COUNT];

    // Access decode
    logic [11:0] base;
    logic [2:0]  count;
    logic [3:0]  lanes;
    logic [3:0]  be;
    logic [31:0] wmask;
    logic [31:0] lane_mask;
    logic [31:0] wdata;
    logic [31:0] value;
    logic        is_write;
    logic        sel_ok;
    logic [QUEUE_COUNT-1:0] hit;
    logic [31:0] size_merged [QUEUE_COUNT];
    logic        wr_qsize, wr_qen;
    logic        wr_desc_lo, wr_desc_hi, wr_avail_lo, wr_avail_hi, wr_used_lo, wr_used_hi;
    logic        notify;
    logic        clear_all;
    logic [31:0] rdata;
    logic        sel_enable;
    logic [QUEUE_COUNT-1:0] live;

    assign base     = {access.offset[11:2], 2'b00};
    assign count    = (access.byte_count > 3'd4) ? 3'd4 : access.byte_count;
    assign is_write = (access.cmd == vmmio_pkg::CMD_WRITE);
    assign sel_ok   = (queue_sel_reg < 32'(QUEUE_COUNT));

    always_comb
    begin
        case (count)
            3'd0:    lanes = 4'b0000;
            3'd1:    lanes = 4'b0001;
            3'd2:    lanes = 4'b0011;
            3'd3:    lanes = 4'b0111;
            default: lanes = 4'b1111;
        endcase
    end

    // Lanes past bit 31 of the word fall off the top
    assign be        = lanes << access.offset[1:0];
    assign wmask     = {{8{be[3]}}, {8{be[2]}}, {8{be[1]}}, {8{be[0]}}};
    assign lane_mask = {{8{lanes[3]}}, {8{lanes[2]}}, {8{lanes[1]}}, {8{lanes[0]}}};
    assign wdata     = access.write_data << {access.offset[1:0], 3'b000};
    assign value     = access.write_data & lane_mask;

    always_comb
    begin
        for (int i = 0; i < QUEUE_COUNT; i++)
        begin
            hit[i] = (queue_sel_reg == 32'(i));
        end
    end

    // Read mux over the current state
    always_comb
    begin
        sel_enable = 1'b0;
        for (int i = 0; i < QUEUE_COUNT; i++)
        begin
            sel_enable = sel_enable | (hit[i] & qen_reg[i]);
        end
    end

    always_comb
    begin
        unique case (base)
            vmmio_pkg::OFF_MAGIC:      rdata = vmmio_pkg::MAGIC_VALUE;
            vmmio_pkg::OFF_VERSION:    rdata = vmmio_pkg::VERSION_VALUE;
            vmmio_pkg::OFF_DEVICE_ID:  rdata = vmmio_pkg::DEVICE_ID_NET;
            vmmio_pkg::OFF_VENDOR_ID:  rdata = vmmio_pkg::VENDOR_VALUE;
            vmmio_pkg::OFF_DEV_FEAT:
            begin
                if (dev_feat_sel_reg == 32'd0)
                    rdata = vmmio_pkg::DEV_FEAT_W0;
                else if (dev_feat_sel_reg == 32'd1)
                    rdata = vmmio_pkg::DEV_FEAT_W1;
                else
                    rdata = 32'd0;
            end
            vmmio_pkg::OFF_QUEUE_MAX:  rdata = sel_ok ? 32'(QUEUE_SIZE_MAX) : 32'd0;
            vmmio_pkg::OFF_QUEUE_READY: rdata = {31'd0, sel_enable};
            vmmio_pkg::OFF_IRQ_STATUS: rdata = {31'd0, irq_reg};
            vmmio_pkg::OFF_STATUS:     rdata = status_reg;
            vmmio_pkg::OFF_MAC_LO:     rdata = mac[31:0];
            vmmio_pkg::OFF_MAC_HI:     rdata = {16'd0, mac[47:32]};
            default:                   rdata = 32'd0;
        endcase
    end

    // Write decode and next state
    always_comb
    begin
        dev_feat_sel_next = dev_feat_sel_reg;
        drv_feat_sel_next = drv_feat_sel_reg;
        drv_feat_next     = drv_feat_reg;
        queue_sel_next    = queue_sel_reg;
        status_next       = status_reg;
        irq_next          = irq_reg;
        wr_qsize          = 1'b0;
        wr_qen            = 1'b0;
        wr_desc_lo        = 1'b0;
        wr_desc_hi        = 1'b0;
        wr_avail_lo       = 1'b0;
        wr_avail_hi       = 1'b0;
        wr_used_lo        = 1'b0;
        wr_used_hi        = 1'b0;
        notify            = 1'b0;
        clear_all         = 1'b0;

        if (access.cmd == vmmio_pkg::CMD_COMPLETE)
            irq_next = 1'b1;

        if (is_write)
        begin
            unique case (base)
                vmmio_pkg::OFF_DEV_FEAT_SEL:
                    dev_feat_sel_next = vmmio_pkg::merge_lanes(dev_feat_sel_reg, wmask, wdata);
                vmmio_pkg::OFF_DRV_FEAT:
                    drv_feat_next[drv_feat_sel_reg] =
                        vmmio_pkg::merge_lanes(drv_feat_reg[drv_feat_sel_reg], wmask, wdata);
                // only bit 0 of the driver feature select is ever used
                vmmio_pkg::OFF_DRV_FEAT_SEL:
                    drv_feat_sel_next = wmask[0] ? wdata[0] : drv_feat_sel_reg;
                vmmio_pkg::OFF_QUEUE_SEL:
                    queue_sel_next = vmmio_pkg::merge_lanes(queue_sel_reg, wmask, wdata);
                vmmio_pkg::OFF_QUEUE_SIZE:  wr_qsize    = 1'b1;
                vmmio_pkg::OFF_QUEUE_READY: wr_qen      = 1'b1;
                vmmio_pkg::OFF_NOTIFY:      notify      = (value == 32'd1);
                vmmio_pkg::OFF_IRQ_ACK:
                begin
                    if (value[0])
                        irq_next = 1'b0;
                end
                vmmio_pkg::OFF_STATUS:
                begin
                    status_next = vmmio_pkg::merge_lanes(status_reg, wmask, wdata);
                    clear_all   = (status_next == 32'd0);
                end
                vmmio_pkg::OFF_DESC_LO:     wr_desc_lo  = 1'b1;
                vmmio_pkg::OFF_DESC_HI:     wr_desc_hi  = 1'b1;
                vmmio_pkg::OFF_AVAIL_LO:    wr_avail_lo = 1'b1;
                vmmio_pkg::OFF_AVAIL_HI:    wr_avail_hi = 1'b1;
                vmmio_pkg::OFF_USED_LO:     wr_used_lo  = 1'b1;
                vmmio_pkg::OFF_USED_HI:     wr_used_hi  = 1'b1;
                default:                    ;
            endcase
        end

        // Per-queue updates, only the selected queue takes a write
        for (int i = 0; i < QUEUE_COUNT; i++)
        begin
            qsize_next[i]  = qsize_reg[i];
            qen_next[i]    = qen_reg[i];
            desc_next[i]   = desc_reg[i];
            avail_next[i]  = avail_reg[i];
            used_next[i]   = used_reg[i];
            size_merged[i] = vmmio_pkg::merge_lanes(32'(qsize_reg[i]), wmask, wdata);
            if (hit[i])
            begin
                if (wr_qsize)
                    qsize_next[i] = (size_merged[i] > 32'(QUEUE_SIZE_MAX)) ?
                                    QSIZE_W'(QUEUE_SIZE_MAX) : size_merged[i][QSIZE_W-1:0];
                if (wr_qen && wmask[0])
                    qen_next[i] = wdata[0];
                if (wr_desc_lo)
                    desc_next[i][31:0] = vmmio_pkg::merge_lanes(desc_reg[i][31:0], wmask, wdata);
                if (wr_desc_hi)
                    desc_next[i][63:32] =
                        vmmio_pkg::merge_lanes(desc_reg[i][63:32], wmask, wdata);
                if (wr_avail_lo)
                    avail_next[i][31:0] =
                        vmmio_pkg::merge_lanes(avail_reg[i][31:0], wmask, wdata);
                if (wr_avail_hi)
                    avail_next[i][63:32] =
                        vmmio_pkg::merge_lanes(avail_reg[i][63:32], wmask, wdata);
                if (wr_used_lo)
                    used_next[i][31:0] = vmmio_pkg::merge_lanes(used_reg[i][31:0], wmask, wdata);
                if (wr_used_hi)
                    used_next[i][63:32] =
                        vmmio_pkg::merge_lanes(used_reg[i][63:32], wmask, wdata);
            end
        end

        // Status written to zero: device reset
        if (clear_all)
        begin
            dev_feat_sel_next = 32'd0;
            drv_feat_sel_next = 1'b0;
            drv_feat_next[0]  = 32'd0;
            drv_feat_next[1]  = 32'd0;
            queue_sel_next    = 32'd0;
            status_next       = 32'd0;
            irq_next          = 1'b0;
            for (int i = 0; i < QUEUE_COUNT; i++)
            begin
                qsize_next[i] = '0;
                qen_next[i]   = 1'b0;
                desc_next[i]  = 64'd0;
                avail_next[i] = 64'd0;
                used_next[i]  = 64'd0;
            end
        end
    end

    // Queue liveness after this access
    always_comb
    begin
        for (int i = 0; i < QUEUE_COUNT; i++)
        begin
            live[i] = qen_next[i] && (|qsize_next[i]) && (|desc_next[i]) &&
                      (|avail_next[i]) && (|used_next[i]) &&
                      status_next[vmmio_pkg::STATUS_DRIVER_OK_BIT];
        end
    end

    assign result.read_data     = (access.cmd == vmmio_pkg::CMD_READ) ? rdata : 32'd0;
    assign result.tx_notify     = notify;
    assign result.irq_pending   = irq_next;
    assign result.rx_queue_live = live[0];

    generate
        if (QUEUE_COUNT > 1)
        begin : g_tx
            assign result.tx_queue_live = live[1];
        end
        else
        begin : g_no_tx
            assign result.tx_queue_live = 1'b0;
        end
    endgenerate

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_feat_sel_reg <= 32'd0;
            drv_feat_sel_reg <= 1'b0;
            drv_feat_reg[0]  <= 32'd0;
            drv_feat_reg[1]  <= 32'd0;
            queue_sel_reg    <= 32'd0;
            status_reg       <= 32'd0;
            irq_reg          <= 1'b0;
            for (int i = 0; i < QUEUE_COUNT; i++)
            begin
                qsize_reg[i] <= '0;
                qen_reg[i]   <= 1'b0;
                desc_reg[i]  <= 64'd0;
                avail_reg[i] <= 64'd0;
                used_reg[i]  <= 64'd0;
            end
        end
        else if (update)
        begin
            dev_feat_sel_reg <= dev_feat_sel_next;
            drv_feat_sel_reg <= drv_feat_sel_next;
            drv_feat_reg     <= drv_feat_next;
            queue_sel_reg    <= queue_sel_next;
            status_reg       <= status_next;
            irq_reg          <= irq_next;
            qsize_reg        <= qsize_next;
            qen_reg          <= qen_next;
            desc_reg         <= desc_next;
            avail_reg        <= avail_next;
            used_reg         <= used_next;
        end
    end

endmodule

[sv/virtio_mmio_register_block.sv]
// virtio-mmio (version 2) network device register block.
// Request channel (req_valid / req_stall / req_data): one bus access per item,
// a register read, a 1..4 byte write at any offset, or a used-ring completion
// that raises interrupt bit 0. Response channel (rsp_valid / rsp_stall /
// rsp_data): exactly one result item per request, in order, carrying the read
// word, the transmit notify pulse, the interrupt bit and both queue-live flags.
// A request that is accepted lands in the input register; when it advances,
// the register file is updated and the result is registered and shown on
// rsp_*. Throughput is one item per cycle unless rsp_stall holds, set by the
// single decode/merge stage between the input and result registers.
// When rsp_stall holds a pending result, the input register still takes one
// more item; req_stall rises only when both stages are full.
// APB port: register 0 (station MAC, 48 bits), paddr not decoded, 64-bit data.
// Reset (rst_n low, asynchronous) empties both stages, clears every device
// register and loads the default MAC 52:54:00:12:34:56.
module virtio_mmio_register_block #(
    parameter int QUEUE_COUNT    = vmmio_pkg::QUEUE_COUNT_DEF,
    parameter int QUEUE_SIZE_MAX = vmmio_pkg::QUEUE_SIZE_MAX_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  vmmio_pkg::access_t                req_data,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output vmmio_pkg::result_t                rsp_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [vmmio_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [vmmio_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [vmmio_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                              pready
);

    logic                         in_valid_reg;
    vmmio_pkg::access_t           access_reg;
    logic                         rsp_valid_reg;
    vmmio_pkg::result_t           rsp_data_reg;
    vmmio_pkg::result_t           result;
    logic [vmmio_pkg::MAC_W-1:0]  mac_reg;
    logic                         accept;
    logic                         advance;
    logic                         cfg_write;

    // Handshake
    assign advance   = in_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = in_valid_reg && rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // Stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
            access_reg <= req_data;
        if (advance)
            rsp_data_reg <= result;
    end

    vmmio_regs #(
        .QUEUE_COUNT    (QUEUE_COUNT),
        .QUEUE_SIZE_MAX (QUEUE_SIZE_MAX)
    ) u_regs (
        .clk    (clk),
        .rst_n  (rst_n),
        .update (advance),
        .access (access_reg),
        .mac    (mac_reg),
        .result (result)
    );

    // APB configuration: single MAC register
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = {{(vmmio_pkg::CFG_DATA_W - vmmio_pkg::MAC_W){1'b0}}, mac_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mac_reg <= vmmio_pkg::MAC_RESET;
        else if (cfg_write)
            mac_reg <= pwdata[vmmio_pkg::MAC_W-1:0];
    end

endmodule

[sv/vmmio_checker.sv]
module vmmio_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              req_valid,
    input logic                              req_stall,
    input vmmio_pkg::access_t                req_data,
    input logic                              rsp_valid,
    input logic                              rsp_stall,
    input vmmio_pkg::result_t                rsp_data,
    input logic                              psel,
    input logic                              penable,
    input logic                              pwrite,
    input logic [vmmio_pkg::CFG_ADDR_W-1:0]  paddr,
    input logic [vmmio_pkg::CFG_DATA_W-1:0]  pwdata,
    input logic [vmmio_pkg::CFG_DATA_W-1:0]  prdata,
    input logic                              pready
);

    // A stalled result item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
    else $error("result item changed while stalled");

    // Requests back up only behind a stalled, full output stage
    assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> rsp_valid && rsp_stall)
    else $error("request stalled with output stage free");

    // A notify comes from a write, which returns no read data
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.tx_notify |-> rsp_data.read_data == 32'd0)
    else $error("notify item carries read data");

    // A MAC write is visible on the read bus the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready |=>
            prdata[vmmio_pkg::MAC_W-1:0] == $past(pwdata[vmmio_pkg::MAC_W-1:0]))
    else $error("configuration write not taken");

endmodule

bind virtio_mmio_register_block vmmio_checker u_checker (.*);
